>>> sv/ubdc_pkg.sv
// ubdc_pkg: shared constants for the UART baud divisor calculator.
// Holds field widths, reset values, parameter defaults and status codes.
// No dependencies.
`timescale 1ns / 1ps

package ubdc_pkg;

  localparam int CLOCK_HZ_DEF    = 16000000;
  localparam int DIVISOR_MAX_DEF = 4095;

  localparam int RATE_W    = 32;
  localparam int DIVISOR_W = 12;
  localparam int STATUS_W  = 2;

  localparam logic [RATE_W-1:0]    RATE_RESET = 32'd115200;
  localparam logic [DIVISOR_W-1:0] DIV_RESET  = 12'd16;
  localparam logic                 DS_RESET   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_HIGH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LOW  = 2'd2;

endpackage

>>> sv/uart_baud_divisor_calculator.sv
// Flow: a rejected rate goes straight to S_FINISH; an accepted one takes one division in
// S_DIV1, and in async mode, when the double-speed divisor is too large, a second one
// in S_DIV2 at normal speed, both on the bit-serial divider, before S_FINISH.
// One item at a time: in_stall stays high from acceptance until the result is loaded.
// Synchronous reset restores 115200 bit/s, divisor 16, double speed, async mode.
// Uses ubdc_pkg and ubdc_divider.
`timescale 1ns / 1ps

module uart_baud_divisor_calculator #(
  parameter int CLOCK_HZ    = ubdc_pkg::CLOCK_HZ_DEF,
  parameter int DIVISOR_MAX = ubdc_pkg::DIVISOR_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ubdc_pkg::RATE_W-1:0]    requested_rate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ubdc_pkg::DIVISOR_W-1:0] divisor,
  output logic                           double_speed,
  output logic [ubdc_pkg::STATUS_W-1:0]  status,
  output logic [ubdc_pkg::RATE_W-1:0]    applied_rate
);

  localparam int NUM_W = $clog2(2 * CLOCK_HZ + 1);
  localparam logic [ubdc_pkg::RATE_W-1:0] SYNC_LIMIT  = ubdc_pkg::RATE_W'(CLOCK_HZ / 2);
  localparam logic [ubdc_pkg::RATE_W-1:0] ASYNC_LIMIT = ubdc_pkg::RATE_W'(CLOCK_HZ / 8);
  localparam logic [NUM_W-1:0] CLK_N = NUM_W'(CLOCK_HZ);
  localparam logic [NUM_W-1:0] MAX_N = NUM_W'(DIVISOR_MAX);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV1   = 4'b0010,
    S_DIV2   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  logic   sync_mode;

  logic [ubdc_pkg::RATE_W-1:0]    rate;
  logic [ubdc_pkg::STATUS_W-1:0]  res_status;
  logic [ubdc_pkg::DIVISOR_W-1:0] res_div;
  logic                           res_ds;

  logic [ubdc_pkg::RATE_W-1:0]    last_good_rate;
  logic [ubdc_pkg::DIVISOR_W-1:0] last_divisor;
  logic                           last_double_speed;

  logic             accept;
  logic             too_high;
  logic             is_zero;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [NUM_W-1:0] div_den;
  logic [NUM_W-1:0] quotient;
  logic [NUM_W-1:0] div_val;
  logic             over;
  logic [NUM_W-1:0] b_n;
  logic [NUM_W-1:0] rate_n;
  logic             out_free;
  logic             res_ok;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign too_high = sync_mode ? (requested_rate > SYNC_LIMIT) : (requested_rate > ASYNC_LIMIT);
  assign is_zero  = (requested_rate == '0);
  assign b_n      = requested_rate[NUM_W-1:0];
  assign rate_n   = rate[NUM_W-1:0];
  assign div_val  = (quotient == '0) ? '0 : (quotient - NUM_W'(1));
  assign over     = div_val > MAX_N;
  assign out_free = !out_valid || !out_stall;
  assign res_ok   = (res_status == ubdc_pkg::ST_OK);

  always_comb begin
    div_start = 1'b0;
    if (accept && !too_high && !is_zero) begin
      div_start = 1'b1;
    end
    if ((state == S_DIV1) && div_done && !sync_mode && over) begin
      div_start = 1'b1;
    end
    if (state == S_IDLE) begin
      if (sync_mode) begin
        div_dividend = CLK_N + b_n;
        div_den      = b_n << 1;
      end else begin
        div_dividend = CLK_N + (b_n << 2);
        div_den      = b_n << 3;
      end
    end else begin
      div_dividend = CLK_N + (rate_n << 3);
      div_den      = rate_n << 4;
    end
  end

  ubdc_divider #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .den_in   (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sync_mode         <= 1'b0;
      out_valid         <= 1'b0;
      last_good_rate    <= ubdc_pkg::RATE_RESET;
      last_divisor      <= ubdc_pkg::DIV_RESET;
      last_double_speed <= ubdc_pkg::DS_RESET;
    end else begin
      if (cfg_wr_en) begin
        sync_mode <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rate   <= requested_rate;
            res_ds <= 1'b0;
            if (too_high) begin
              res_status <= ubdc_pkg::ST_TOO_HIGH;
              state      <= S_FINISH;
            end else if (is_zero) begin
              res_status <= ubdc_pkg::ST_TOO_LOW;
              state      <= S_FINISH;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            res_div <= div_val[ubdc_pkg::DIVISOR_W-1:0];
            if (sync_mode) begin
              res_ds     <= 1'b0;
              res_status <= over ? ubdc_pkg::ST_TOO_LOW : ubdc_pkg::ST_OK;
              state      <= S_FINISH;
            end else if (!over) begin
              res_ds     <= 1'b1;
              res_status <= ubdc_pkg::ST_OK;
              state      <= S_FINISH;
            end else begin
              state <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_done) begin
            res_div    <= div_val[ubdc_pkg::DIVISOR_W-1:0];
            res_ds     <= 1'b0;
            res_status <= over ? ubdc_pkg::ST_TOO_LOW : ubdc_pkg::ST_OK;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (res_ok) begin
              last_good_rate    <= rate;
              last_divisor      <= res_div;
              last_double_speed <= res_ds;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      status       <= res_status;
      divisor      <= res_ok ? res_div : last_divisor;
      double_speed <= res_ok ? res_ds : last_double_speed;
      applied_rate <= res_ok ? rate : last_good_rate;
    end
  end

endmodule

>>> sv/ubdc_divider.sv
// ubdc_divider: restoring unsigned divider, one quotient bit per cycle.
// Shared by every divisor computation of the calculator; no package use.
`timescale 1ns / 1ps

module ubdc_divider #(
  parameter int NUM_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] den_in,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] den;
  logic [NUM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [NUM_W:0]   rem_sh;
  logic             qbit;
  logic [NUM_W:0]   rem_sub;

  assign rem_sh   = {rem, num[NUM_W-1]};
  assign qbit     = rem_sh >= {1'b0, den};
  assign rem_sub  = qbit ? (rem_sh - {1'b0, den}) : rem_sh;
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= dividend;
        den  <= den_in;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_sub[NUM_W-1:0];
        num <= {num[NUM_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/ubdc_checker.sv
// ubdc_assert_checker: port-level assertions for uart_baud_divisor_calculator.
// Uses ubdc_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module ubdc_assert_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ubdc_pkg::DIVISOR_W-1:0] divisor,
  input logic                           double_speed,
  input logic [ubdc_pkg::STATUS_W-1:0]  status,
  input logic [ubdc_pkg::RATE_W-1:0]    applied_rate
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ubdc_pkg::ST_OK || status == ubdc_pkg::ST_TOO_HIGH ||
                   status == ubdc_pkg::ST_TOO_LOW))
    else $error("undefined status code");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(divisor) && $stable(double_speed) &&
                                  $stable(status) && $stable(applied_rate)))
    else $error("stalled result item changed");

endmodule

bind uart_baud_divisor_calculator ubdc_assert_checker u_ubdc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .divisor      (divisor),
  .double_speed (double_speed),
  .status       (status),
  .applied_rate (applied_rate)
);

>>> tb/sv/ubdc_checker.sv
// ubdc_checker: watches the rate request and result channels of the baud divisor
// calculator, predicts each applied setting and compares it field by field.
// Depends on ubdc_pkg for widths, reset values and status codes.
`timescale 1ns / 1ps

module ubdc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ubdc_pkg::RATE_W-1:0]    requested_rate,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ubdc_pkg::DIVISOR_W-1:0] divisor,
  input  logic                           double_speed,
  input  logic [ubdc_pkg::STATUS_W-1:0]  status,
  input  logic [ubdc_pkg::RATE_W-1:0]    applied_rate,
  output int                             mismatches,
  output int                             settings_owed
);

  localparam logic [63:0] CLK_HZ  = 64'(ubdc_pkg::CLOCK_HZ_DEF);
  localparam logic [63:0] DIV_MAX = 64'(ubdc_pkg::DIVISOR_MAX_DEF);

  typedef struct packed {
    logic [ubdc_pkg::DIVISOR_W-1:0] divisor;
    logic                           double_speed;
    logic [ubdc_pkg::STATUS_W-1:0]  status;
    logic [ubdc_pkg::RATE_W-1:0]    rate;
  } baud_setting_t;

  baud_setting_t                  settings_due[$];
  logic [ubdc_pkg::RATE_W-1:0]    good_rate;
  logic [ubdc_pkg::DIVISOR_W-1:0] good_div;
  logic                           good_ds;
  logic                           sync_mode;

  function automatic logic [63:0] rounded_divisor(logic [63:0] rate, logic [63:0] half,
                                                  logic [63:0] full);
    logic [63:0] q;
    q = (CLK_HZ + half * rate) / (full * rate);
    return (q == 64'd0) ? 64'd0 : q - 64'd1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    logic [63:0]                   b;
    logic [63:0]                   div;
    logic                          ds;
    logic [ubdc_pkg::STATUS_W-1:0] st;
    baud_setting_t                 want;
    if (rst) begin
      mismatches = 0;
      good_rate  = ubdc_pkg::RATE_RESET;
      good_div   = ubdc_pkg::DIV_RESET;
      good_ds    = ubdc_pkg::DS_RESET;
      sync_mode  = 1'b0;
      settings_due.delete();
    end else begin
      if (cfg_wr_en) begin
        sync_mode = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (settings_due.size() == 0) begin
          mismatches++;
          $display("%0t: expected no item, got divisor %0d ds %0d status %0d rate %0d",
                   $time, divisor, double_speed, status, applied_rate);
        end else begin
          want = settings_due.pop_front();
          check_field("divisor", 32'(want.divisor), 32'(divisor));
          check_field("double_speed", 32'(want.double_speed), 32'(double_speed));
          check_field("status", 32'(want.status), 32'(status));
          check_field("applied_rate", want.rate, applied_rate);
        end
      end
      if (in_valid && !in_stall) begin
        b   = {32'd0, requested_rate};
        st  = ubdc_pkg::ST_OK;
        div = 64'd0;
        ds  = 1'b0;
        if (sync_mode) begin
          if (b > CLK_HZ / 64'd2) begin
            st = ubdc_pkg::ST_TOO_HIGH;
          end else if (b == 64'd0) begin
            st = ubdc_pkg::ST_TOO_LOW;
          end else begin
            div = rounded_divisor(b, 64'd1, 64'd2);
            if (div > DIV_MAX) st = ubdc_pkg::ST_TOO_LOW;
          end
        end else begin
          if (b > CLK_HZ / 64'd8) begin
            st = ubdc_pkg::ST_TOO_HIGH;
          end else if (b == 64'd0) begin
            st = ubdc_pkg::ST_TOO_LOW;
          end else begin
            div = rounded_divisor(b, 64'd4, 64'd8);
            ds  = 1'b1;
            if (div > DIV_MAX) begin
              div = rounded_divisor(b, 64'd8, 64'd16);
              ds  = 1'b0;
              if (div > DIV_MAX) st = ubdc_pkg::ST_TOO_LOW;
            end
          end
        end
        if (st == ubdc_pkg::ST_OK) begin
          good_rate = b[ubdc_pkg::RATE_W-1:0];
          good_div  = div[ubdc_pkg::DIVISOR_W-1:0];
          good_ds   = ds;
        end
        want.divisor      = good_div;
        want.double_speed = good_ds;
        want.status       = st;
        want.rate         = good_rate;
        settings_due.push_back(want);
      end
    end
    settings_owed = settings_due.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: drives baud rate requests and mode writes into the divisor calculator,
// with random idle and stall bursts, and reports the verdict of ubdc_checker.
// Depends on ubdc_pkg, ubdc_checker and uart_baud_divisor_calculator.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 200;
  localparam int PHASES         = 7;
  localparam int DRAIN_CYCLES   = 100;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic                           cfg_wr_data = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ubdc_pkg::RATE_W-1:0]    requested_rate = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ubdc_pkg::DIVISOR_W-1:0] divisor;
  logic                           double_speed;
  logic [ubdc_pkg::STATUS_W-1:0]  status;
  logic [ubdc_pkg::RATE_W-1:0]    applied_rate;

  int   mismatches;
  int   settings_owed;
  int   stall_left = 0;
  int   idle_cycles;
  logic calm = 1'b0;
  logic sync_sel = 1'b0;

  int unsigned common_rates[14] = '{300, 1200, 2400, 9600, 19200, 38400, 57600, 115200,
                                    230400, 460800, 921600, 1000000, 2000000, 4000000};
  logic [31:0] async_rates[12] = '{32'd0, 32'd1, 32'd244, 32'd245, 32'd488, 32'd489,
                                   32'd1953, 32'd9600, 32'd115200, 32'd2000000,
                                   32'd2000001, 32'hFFFF_FFFF};
  logic [31:0] sync_rates[8] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd1952, 32'd1953,
                                 32'd300, 32'd8000000, 32'd8000001};

  uart_baud_divisor_calculator u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .requested_rate (requested_rate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .divisor        (divisor),
    .double_speed   (double_speed),
    .status         (status),
    .applied_rate   (applied_rate)
  );

  ubdc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .requested_rate (requested_rate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .divisor        (divisor),
    .double_speed   (double_speed),
    .status         (status),
    .applied_rate   (applied_rate),
    .mismatches     (mismatches),
    .settings_owed  (settings_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && !rst && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_rate(input logic [ubdc_pkg::RATE_W-1:0] rate);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    requested_rate <= rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every result is back, then write the mode register.
  task automatic write_mode(input logic sync);
    in_valid <= 1'b0;
    @(negedge clk);
    while (settings_owed != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sync;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sync_sel = sync;
  endtask

  function automatic logic [ubdc_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 300);
      2:       return $urandom_range(200, 3000);
      3:       return $urandom_range(1, 2100000);
      4:       return $urandom_range(1900000, 8100000);
      5:       return common_rates[$urandom_range(0, 13)];
      default: return $urandom_range(1, sync_sel ? 8000000 : 2000000);
    endcase
  endfunction

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (async_rates[i]) send_rate(async_rates[i]);
    write_mode(1'b1);
    foreach (sync_rates[i]) send_rate(sync_rates[i]);
    for (int phase = 0; phase < PHASES; phase++) begin
      write_mode(phase[0]);
      if (phase == PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) send_rate(pick_rate());
    end
    in_valid <= 1'b0;
    while (settings_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && settings_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
